@@ hdl/assert_macros.svh @@
// ------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the checker
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mbsp_pkg.sv @@
// ------------------------------------------------------------------------
// mbsp_pkg
// types and constants shared by the media box stream parser
// ------------------------------------------------------------------------
package mbsp_pkg;

   localparam logic [63:0] MAX_BOX_SIZE_RESET = 64'd53687091200;
   localparam logic [5:0]  BASE_HDR_LEN       = 6'd8;
   localparam logic [5:0]  LONG_SIZE_LEN      = 6'd8;
   localparam logic [5:0]  EXT_TYPE_LEN       = 6'd16;
   localparam logic [31:0] UUID_FOURCC        = 32'h75756964;
   localparam logic [31:0] LONG_SIZE_MARK     = 32'd1;
   localparam int          HDR_DEPTH          = 32;

   typedef enum logic [2:0] {
      EV_OPEN    = 3'd0,
      EV_DATA    = 3'd1,
      EV_CLOSE   = 3'd2,
      EV_CORRUPT = 3'd3,
      EV_EOS     = 3'd4
   } box_event_type;

   // one accepted input beat worth of results: a primary result and
   // optionally a trailing close or end of stream
   typedef struct packed {
      box_event_type ev;
      logic [31:0]   box_type;
      logic          has_ext;
      logic [63:0]   ext_hi;
      logic [63:0]   ext_lo;
      logic [63:0]   box_size;
      logic [7:0]    payload;
      logic          has_second;
      box_event_type second_ev;
   } rsp_item_type;

   // one result beat
   typedef struct packed {
      box_event_type ev;
      logic [31:0]   box_type;
      logic          has_ext;
      logic [63:0]   ext_hi;
      logic [63:0]   ext_lo;
      logic [63:0]   box_size;
      logic [7:0]    payload;
      logic          last;
   } rsp_beat_type;

endpackage

@@ hdl/mbsp_parse.sv @@
// ------------------------------------------------------------------------
// mbsp_parse
// header gathering, header check, payload tracking and error state
// ------------------------------------------------------------------------
module mbsp_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [63:0]           csr_wr_data,
   input  logic                  beat_acc,
   input  logic                  beat_kind,
   input  logic [7:0]            beat_byte,
   output logic                  item_valid,
   output mbsp_pkg::rsp_item_type item
);

   logic [63:0] max_size_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        in_box_ff, in_box_in;
   logic        sized_ff, sized_in;
   logic [63:0] left_ff, left_in;
   logic        err_ff, err_in;
   logic [7:0]  hdr_ff [mbsp_pkg::HDR_DEPTH];
   logic        hdr_we;

   logic [7:0]  hb [mbsp_pkg::HDR_DEPTH];
   logic [5:0]  nc;
   logic [31:0] size32;
   logic [31:0] fourcc;
   logic        long_size;
   logic        is_uuid;
   logic [5:0]  need;
   logic [63:0] size;
   logic        too_small;
   logic        bad;
   logic        hdr_done;
   logic [63:0] left_sub;
   logic [63:0] left_dec;

   // current byte seen in place of the entry it is about to overwrite
   always_comb begin
      for (int i = 0; i < mbsp_pkg::HDR_DEPTH; i++) begin
         hb[i] = (5'(i) == cnt_ff[4:0]) ? beat_byte : hdr_ff[i];
      end
   end

   always_comb begin
      nc        = cnt_ff + 6'd1;
      size32    = {hb[0], hb[1], hb[2], hb[3]};
      fourcc    = {hb[4], hb[5], hb[6], hb[7]};
      long_size = (size32 == mbsp_pkg::LONG_SIZE_MARK);
      is_uuid   = (fourcc == mbsp_pkg::UUID_FOURCC);
      need      = mbsp_pkg::BASE_HDR_LEN
                  + (long_size ? mbsp_pkg::LONG_SIZE_LEN : 6'd0)
                  + (is_uuid ? mbsp_pkg::EXT_TYPE_LEN : 6'd0);
      size      = long_size ? {hb[8], hb[9], hb[10], hb[11], hb[12], hb[13], hb[14], hb[15]}
                            : {32'd0, size32};
      too_small = (size[63:6] == 58'd0) && (size[5:0] < need);
      bad       = (size > max_size_ff) || (too_small && (long_size || (size != 64'd0)));
      hdr_done  = (nc >= mbsp_pkg::BASE_HDR_LEN) && (nc >= need);
      left_sub  = size - {58'd0, need};
      left_dec  = (left_ff != 64'd0) ? left_ff - 64'd1 : 64'd0;
   end

   always_comb begin
      cnt_in     = cnt_ff;
      in_box_in  = in_box_ff;
      sized_in   = sized_ff;
      left_in    = left_ff;
      err_in     = err_ff;
      hdr_we     = 1'b0;
      item_valid = 1'b0;
      item       = '0;
      if (beat_acc) begin
         if (err_ff) begin
            item_valid = 1'b1;
            item.ev    = mbsp_pkg::EV_CORRUPT;
         end else if (beat_kind) begin
            item_valid = 1'b1;
            in_box_in  = 1'b0;
            sized_in   = 1'b0;
            left_in    = 64'd0;
            cnt_in     = 6'd0;
            if (in_box_ff && sized_ff) begin
               err_in  = 1'b1;
               item.ev = mbsp_pkg::EV_CORRUPT;
            end else if (in_box_ff) begin
               item.ev         = mbsp_pkg::EV_CLOSE;
               item.has_second = 1'b1;
               item.second_ev  = mbsp_pkg::EV_EOS;
            end else begin
               item.ev = mbsp_pkg::EV_EOS;
            end
         end else if (in_box_ff) begin
            item_valid   = 1'b1;
            item.ev      = mbsp_pkg::EV_DATA;
            item.payload = beat_byte;
            if (sized_ff) begin
               left_in = left_dec;
               if (left_dec == 64'd0) begin
                  in_box_in       = 1'b0;
                  item.has_second = 1'b1;
                  item.second_ev  = mbsp_pkg::EV_CLOSE;
               end
            end
         end else begin
            hdr_we = 1'b1;
            cnt_in = nc;
            if (hdr_done) begin
               cnt_in     = 6'd0;
               item_valid = 1'b1;
               if (bad) begin
                  err_in  = 1'b1;
                  item.ev = mbsp_pkg::EV_CORRUPT;
               end else begin
                  item.ev       = mbsp_pkg::EV_OPEN;
                  item.box_type = fourcc;
                  item.box_size = size;
                  if (is_uuid) begin
                     item.has_ext = 1'b1;
                     item.ext_hi  = long_size
                        ? {hb[16], hb[17], hb[18], hb[19], hb[20], hb[21], hb[22], hb[23]}
                        : {hb[8], hb[9], hb[10], hb[11], hb[12], hb[13], hb[14], hb[15]};
                     item.ext_lo  = long_size
                        ? {hb[24], hb[25], hb[26], hb[27], hb[28], hb[29], hb[30], hb[31]}
                        : {hb[16], hb[17], hb[18], hb[19], hb[20], hb[21], hb[22], hb[23]};
                  end
                  sized_in  = (size != 64'd0);
                  left_in   = (size != 64'd0) ? left_sub : 64'd0;
                  in_box_in = 1'b1;
                  if ((size != 64'd0) && (left_sub == 64'd0)) begin
                     in_box_in       = 1'b0;
                     item.has_second = 1'b1;
                     item.second_ev  = mbsp_pkg::EV_CLOSE;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= mbsp_pkg::MAX_BOX_SIZE_RESET;
         cnt_ff      <= 6'd0;
         in_box_ff   <= 1'b0;
         sized_ff    <= 1'b0;
         left_ff     <= 64'd0;
         err_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_size_ff <= csr_wr_data;
         end
         cnt_ff    <= cnt_in;
         in_box_ff <= in_box_in;
         sized_ff  <= sized_in;
         left_ff   <= left_in;
         err_ff    <= err_in;
      end
   end

   // header byte store, no reset
   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[cnt_ff[4:0]] <= beat_byte;
      end
   end

endmodule

@@ hdl/mbsp_rsp_queue.sv @@
// ------------------------------------------------------------------------
// mbsp_rsp_queue
// two-slot result queue, splits an item into one or two result beats
// ------------------------------------------------------------------------
module mbsp_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mbsp_pkg::rsp_item_type push_item,
   output logic                   has_room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mbsp_pkg::rsp_beat_type out_beat
);

   mbsp_pkg::rsp_item_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       half_ff;

   mbsp_pkg::rsp_item_type head;
   logic       pop_beat;
   logic       pop_item;

   always_comb begin
      head      = slot_ff[rd_ptr_ff];
      out_valid = (count_ff != 2'd0);
      has_room  = (count_ff != 2'd2);
      pop_beat  = out_valid && out_ready;
      pop_item  = pop_beat && (half_ff || !head.has_second);
      out_beat  = '0;
      if (half_ff) begin
         out_beat.ev   = head.second_ev;
         out_beat.last = 1'b1;
      end else begin
         out_beat.ev       = head.ev;
         out_beat.box_type = head.box_type;
         out_beat.has_ext  = head.has_ext;
         out_beat.ext_hi   = head.ext_hi;
         out_beat.ext_lo   = head.ext_lo;
         out_beat.box_size = head.box_size;
         out_beat.payload  = head.payload;
         out_beat.last     = !head.has_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         half_ff   <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_item) begin
            rd_ptr_ff <= !rd_ptr_ff;
            half_ff   <= 1'b0;
         end else if (pop_beat) begin
            half_ff <= 1'b1;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop_item};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/mp4_box_stream_parser.sv @@
// ------------------------------------------------------------------------
// mp4_box_stream_parser
// box header parser for a byte stream of ISO media boxes
// ------------------------------------------------------------------------
// req channel: one beat per stream byte (req_tuser low) or end of stream
// (req_tuser high). rsp channel: box open, payload byte, box close,
// corrupted and end of stream beats; rsp_tlast marks the last beat that
// one request beat causes. csr_wr_en loads the maximum box size.
// A request beat is parsed in the cycle it is accepted and its results
// sit in a two-slot result queue; the first result is offered from the
// registered queue slot. One request beat per cycle is taken while
// each causes at most one result and rsp_tready is high; a beat that
// causes two results (open or payload followed by close, close followed
// by end of stream) is two rsp beats; the single rsp port sets the rate.
// When the receiver stalls, the queue holds up to two request beats of
// results, then req_tready drops. Reset empties the queue, drops any
// partial header, clears the error state and loads the maximum box size
// of 50 GiB. After a corrupted result every later beat yields corrupted
// until reset.
// ------------------------------------------------------------------------
module mp4_box_stream_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // box_type, extended_type_high, extended_type_low, box_size, payload_byte
   output logic [231:0] rsp_tdata,
   output logic [3:0]   rsp_tuser,   // event_res, has_extended_type
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [63:0]  csr_wr_data
);

   logic                   beat_acc;
   logic                   item_valid;
   mbsp_pkg::rsp_item_type item;
   mbsp_pkg::rsp_beat_type beat;

   assign beat_acc = req_tvalid && req_tready;

   mbsp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .beat_acc    (beat_acc),
      .beat_kind   (req_tuser),
      .beat_byte   (req_tdata),
      .item_valid  (item_valid),
      .item        (item)
   );

   mbsp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_valid),
      .push_item (item),
      .has_room  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (beat)
   );

   assign rsp_tdata = {beat.payload, beat.box_size, beat.ext_lo, beat.ext_hi, beat.box_type};
   assign rsp_tuser = {beat.has_ext, beat.ev};
   assign rsp_tlast = beat.last;

endmodule

@@ hdl/mbsp_checker.sv @@
// ------------------------------------------------------------------------
// mbsp_checker
// port-level checks on the result channel of the box stream parser
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module mbsp_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [231:0] rsp_tdata,
   input logic [3:0]   rsp_tuser
);

   `ASSERT_CLK(a_idle_after_reset, clock, reset |=> !rsp_tvalid, "result beat right after reset")

   `ASSERT_RST(a_ext_only_on_open, clock, reset, (rsp_tvalid && rsp_tuser[3]) |-> (rsp_tuser[2:0] == mbsp_pkg::EV_OPEN), "extended type flag outside box open")

   `ASSERT_RST(a_payload_only_on_data, clock, reset, (rsp_tvalid && (rsp_tuser[2:0] != mbsp_pkg::EV_DATA)) |-> (rsp_tdata[231:224] == 8'd0), "payload byte on a non-data beat")

   `ASSERT_RST(a_corrupt_sticks, clock, reset, (rsp_tvalid && rsp_tready && (rsp_tuser[2:0] == mbsp_pkg::EV_CORRUPT)) |=> (!rsp_tvalid || (rsp_tuser[2:0] == mbsp_pkg::EV_CORRUPT)), "beat other than corrupted after corruption")

   `ASSERT_RST(a_stall_holds, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled result beat changed")

endmodule

bind mp4_box_stream_parser mbsp_checker u_mbsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
